FILE: rtl/lift_pi_pkg.sv
// Shared types and constants for the lift height PI controller.
// No dependencies; imported by lift_pi_ctrl and lift_height_pi_register_slave.
`default_nettype none

package lift_pi_pkg;

  localparam int NumRegs        = 12;
  localparam int NumLineSensors = 5;
  localparam int LineSlots      = 5;
  localparam int PtrW           = $clog2(NumRegs);

  typedef enum logic [1:0] {
    FuncWrite  = 2'd0,
    FuncRead   = 2'd1,
    FuncTick   = 2'd2,
    FuncSensor = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KindReadByte = 2'd0,
    KindSpeed    = 2'd1,
    KindThresh   = 2'd2
  } kind_e;

  // Outcome of one PI tick
  typedef struct packed {
    logic signed [15:0] integral;
    logic signed [7:0]  speed;
  } pi_out_t;

endpackage

`default_nettype wire

FILE: rtl/lift_pi_ctrl.sv
// One PI step of the height loop: error, saturated integral, speed clamp, end stops.
// Depends on lift_pi_pkg.
`default_nettype none

module lift_pi_ctrl (
  input  logic [7:0]           setpoint_i,
  input  logic [7:0]           height_i,
  input  logic signed [15:0]   integral_i,
  output lift_pi_pkg::pi_out_t pi_o
);
  import lift_pi_pkg::*;

  localparam logic [15:0] Recip12    = 16'd43691;  // ceil(2^19 / 12), exact for |x| <= 2^15
  localparam logic [7:0]  HeightLow  = 8'd15;
  localparam logic [7:0]  HeightHigh = 8'd240;
  localparam logic signed [13:0] SpeedMax = 14'sd127;
  localparam logic signed [13:0] SpeedMin = -14'sd127;

  logic signed [8:0]  err;
  logic signed [9:0]  err_bias;
  logic signed [9:0]  err_div4;
  logic signed [16:0] acc;
  logic signed [15:0] acc_sat;
  logic [15:0]        acc_mag;
  logic [31:0]        prod;
  logic [12:0]        quo_mag;
  logic signed [13:0] quo;
  logic signed [13:0] sum;
  logic signed [13:0] clamped;
  logic signed [7:0]  speed;

  always_comb begin
    err      = $signed({1'b0, setpoint_i}) - $signed({1'b0, height_i});
    // truncate toward zero
    err_bias = {err[8], err} + (err[8] ? 10'sd3 : 10'sd0);
    err_div4 = err_bias >>> 2;
    acc      = {integral_i[15], integral_i} + {{7{err_div4[9]}}, err_div4};
    if (acc > 17'sd32767) begin
      acc_sat = 16'sh7FFF;
    end else if (acc < -17'sd32768) begin
      acc_sat = 16'sh8000;
    end else begin
      acc_sat = acc[15:0];
    end
    acc_mag = acc_sat[15] ? (~acc_sat + 16'd1) : acc_sat;
    prod    = acc_mag * Recip12;
    quo_mag = prod[31:19];
    quo     = acc_sat[15] ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
    sum     = quo + $signed({{3{err[8]}}, err, 2'b00});
    if (sum > SpeedMax) begin
      clamped = SpeedMax;
    end else if (sum < SpeedMin) begin
      clamped = SpeedMin;
    end else begin
      clamped = sum;
    end
    speed = clamped[7:0];
    if ((height_i < HeightLow) && clamped[13]) begin
      speed = 8'sd0;
    end
    if ((height_i > HeightHigh) && (clamped > 14'sd0)) begin
      speed = 8'sd0;
    end
    pi_o.integral = acc_sat;
    pi_o.speed    = speed;
  end

endmodule

`default_nettype wire

FILE: rtl/lift_height_pi_register_slave.sv
// Lift height controller with register bank, bus/sensor/tick front end and APB config.
// Result is registered: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle; output register stalls only when a result is not taken.
// Reset (rst_ni low, async): pointer 0, setpoint 100, thresholds 0/150, sensor bytes 0,
// integral 0, tracking id 0x41, serial 0x12; both pipeline registers empty.
// Depends on lift_pi_pkg and lift_pi_ctrl.
`default_nettype none

module lift_height_pi_register_slave (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  reg_index_i,
  input  logic        has_data_i,
  input  logic [7:0]  write_data_i,
  input  logic [9:0]  height_adc_i,
  input  logic [7:0]  line_position_i,
  input  logic [9:0]  line_adc_0_i,
  input  logic [9:0]  line_adc_1_i,
  input  logic [9:0]  line_adc_2_i,
  input  logic [9:0]  line_adc_3_i,
  input  logic [9:0]  line_adc_4_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  read_byte_o,
  output logic signed [7:0] motor_speed_o,
  output logic        threshold_select_o,
  output logic [7:0]  threshold_value_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lift_pi_pkg::*;

  localparam logic [3:0] IdxTrackingId = 4'd0;
  localparam logic [3:0] IdxSerial     = 4'd1;
  localparam logic [3:0] IdxHeight     = 4'd2;
  localparam logic [3:0] IdxSetpoint   = 4'd3;
  localparam logic [3:0] IdxLinePos    = 4'd4;
  localparam logic [3:0] IdxThreshHigh = 4'd5;
  localparam logic [3:0] IdxThreshLow  = 4'd6;
  localparam logic [3:0] IdxLineFirst  = 4'd7;
  localparam logic [3:0] IdxLineLast   = 4'(IdxLineFirst + LineSlots - 1);
  localparam logic       CfgTrackingId = 1'b0;
  localparam logic       CfgSerial     = 1'b1;
  localparam logic [7:0] FullScale     = 8'd255;

  // ---------------- config registers ----------------
  logic [7:0] tracking_id_q, serial_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_id_q <= 8'h41;
      serial_q      <= 8'h12;
    end else if (cfg_wr) begin
      if (paddr[2] == CfgTrackingId) begin
        tracking_id_q <= pwdata[7:0];
      end else begin
        serial_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = {24'd0, (paddr[2] == CfgSerial) ? serial_q : tracking_id_q};

  // ---------------- input register ----------------
  logic       in_vld_q;
  func_e      func_q;
  logic [7:0] idx_q;
  logic       has_q;
  logic [7:0] data_q;
  logic [9:0] hadc_q;
  logic [7:0] lpos_q;
  logic [9:0] ladc_q [LineSlots];
  logic [9:0] ladc_in [LineSlots];
  logic       in_acc;
  logic       adv;

  assign ladc_in[0] = line_adc_0_i;
  assign ladc_in[1] = line_adc_1_i;
  assign ladc_in[2] = line_adc_2_i;
  assign ladc_in[3] = line_adc_3_i;
  assign ladc_in[4] = line_adc_4_i;

  assign in_ready_o = !in_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_e'(func_i);
      idx_q  <= reg_index_i;
      has_q  <= has_data_i;
      data_q <= write_data_i;
      hadc_q <= height_adc_i;
      lpos_q <= line_position_i;
      for (int i = 0; i < LineSlots; i++) begin
        ladc_q[i] <= ladc_in[i];
      end
    end
  end

  // ---------------- controller state ----------------
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic [7:0]         sp_q, sp_d;
  logic [7:0]         th_hi_q, th_hi_d;
  logic [7:0]         th_lo_q, th_lo_d;
  logic [7:0]         height_q, height_d;
  logic [7:0]         lpos_reg_q, lpos_reg_d;
  logic [7:0]         lval_q [LineSlots];
  logic [7:0]         lval_d [LineSlots];
  logic signed [15:0] integ_q, integ_d;
  pi_out_t            pi;

  lift_pi_ctrl u_pi (
    .setpoint_i (sp_q),
    .height_i   (height_q),
    .integral_i (integ_q),
    .pi_o       (pi)
  );

  logic       idx_ok;
  logic       has_res;
  kind_e      kind;
  logic [7:0] rd_byte;
  logic [2:0] line_sel;
  logic [3:0] ptr_ext;

  assign idx_ok   = idx_q < 8'(NumRegs);
  assign ptr_ext  = 4'(ptr_q);
  assign line_sel = 3'(ptr_ext - IdxLineFirst);

  always_comb begin
    case (ptr_ext) inside
      IdxTrackingId:               rd_byte = tracking_id_q;
      IdxSerial:                   rd_byte = serial_q;
      IdxHeight:                   rd_byte = height_q;
      IdxSetpoint:                 rd_byte = sp_q;
      IdxLinePos:                  rd_byte = lpos_reg_q;
      IdxThreshHigh:               rd_byte = th_hi_q;
      IdxThreshLow:                rd_byte = th_lo_q;
      [IdxLineFirst:IdxLineLast]:  rd_byte = lval_q[line_sel];
      default:                     rd_byte = 8'd0;
    endcase
  end

  always_comb begin
    ptr_d      = ptr_q;
    sp_d       = sp_q;
    th_hi_d    = th_hi_q;
    th_lo_d    = th_lo_q;
    height_d   = height_q;
    lpos_reg_d = lpos_reg_q;
    integ_d    = integ_q;
    for (int i = 0; i < LineSlots; i++) begin
      lval_d[i] = lval_q[i];
    end
    has_res = 1'b0;
    kind    = KindReadByte;
    case (func_q)
      FuncWrite: begin
        if (idx_ok) begin
          ptr_d = PtrW'(idx_q);
          if (has_q) begin
            if (idx_q[3:0] == IdxSetpoint) begin
              sp_d    = data_q;
              integ_d = 16'sd0;
            end else if (idx_q[3:0] == IdxThreshHigh) begin
              th_hi_d = data_q;
              has_res = 1'b1;
              kind    = KindThresh;
            end else if (idx_q[3:0] == IdxThreshLow) begin
              th_lo_d = data_q;
              has_res = 1'b1;
              kind    = KindThresh;
            end
          end
        end
      end
      FuncRead: begin
        has_res = 1'b1;
        kind    = KindReadByte;
        ptr_d   = (ptr_q == PtrW'(NumRegs - 1)) ? '0 : ptr_q + 1'b1;
      end
      FuncTick: begin
        has_res = 1'b1;
        kind    = KindSpeed;
        integ_d = pi.integral;
      end
      FuncSensor: begin
        height_d   = FullScale - hadc_q[9:2];
        lpos_reg_d = lpos_q;
        for (int i = 0; i < NumLineSensors; i++) begin
          lval_d[i] = ladc_q[i][9:2];
        end
      end
      default: begin
      end
    endcase
  end

  assign adv = in_vld_q && (!has_res || !out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      sp_q       <= 8'd100;
      th_hi_q    <= 8'd0;
      th_lo_q    <= 8'd150;
      height_q   <= 8'd0;
      lpos_reg_q <= 8'd0;
      integ_q    <= 16'sd0;
      for (int i = 0; i < LineSlots; i++) begin
        lval_q[i] <= 8'd0;
      end
    end else if (adv) begin
      ptr_q      <= ptr_d;
      sp_q       <= sp_d;
      th_hi_q    <= th_hi_d;
      th_lo_q    <= th_lo_d;
      height_q   <= height_d;
      lpos_reg_q <= lpos_reg_d;
      integ_q    <= integ_d;
      for (int i = 0; i < LineSlots; i++) begin
        lval_q[i] <= lval_d[i];
      end
    end
  end

  // ---------------- result register ----------------
  logic       out_vld_q;
  logic [1:0] kind_q;
  logic [7:0] rbyte_q;
  logic [7:0] speed_q;
  logic       tsel_q;
  logic [7:0] tval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && has_res) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // unused fields of a word read as zero
  always_ff @(posedge clk_i) begin
    if (adv && has_res) begin
      kind_q  <= kind;
      rbyte_q <= (kind == KindReadByte) ? rd_byte : 8'd0;
      speed_q <= (kind == KindSpeed) ? pi.speed : 8'd0;
      tsel_q  <= (kind == KindThresh) && (idx_q[3:0] == IdxThreshLow);
      tval_q  <= (kind == KindThresh) ? data_q : 8'd0;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign result_kind_o      = kind_q;
  assign read_byte_o        = rbyte_q;
  assign motor_speed_o      = speed_q;
  assign threshold_select_o = tsel_q;
  assign threshold_value_o  = tval_q;

  // ---------------- assertions ----------------
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q < PtrW'(NumRegs))
    else $error("register pointer out of range");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KindSpeed) |-> (motor_speed_o != 8'sh80))
    else $error("motor speed outside +-127");

  a_setpoint_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (func_q == FuncWrite) && idx_ok && has_q && (idx_q[3:0] == IdxSetpoint)
    |=> (integ_q == 16'sd0))
    else $error("setpoint write did not clear integral");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
